// File: hw/rtl/dtrm_pkg.sv
// shared types, constants and helpers for the decimal text statistics block
`default_nettype none

package dtrm_pkg;

	localparam int FRAC_BITS_DEF       = 16;
	localparam int VALUE_WIDTH_DEF     = 32;
	localparam int COUNT_WIDTH_DEF     = 24;
	localparam int MAX_FRAC_DIGITS_DEF = 6;

	localparam int KW_LEN = 9;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	localparam logic [3:0] POS_MAX = 4'd15;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_BAD   = 2'd2;

	// what the last character of a token asks for
	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_STATS = 2'd1,
		EV_EMPTY = 2'd2,
		EV_BAD   = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic step;
		logic start_div;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		event_kind_t ev;
		logic        div_busy;
	} ctrl_stat_t;

	// letters of the word calculate by position
	function automatic logic [7:0] kw_char(input logic [3:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0:    c = 8'h63;
			4'd1:    c = 8'h61;
			4'd2:    c = 8'h6c;
			4'd3:    c = 8'h63;
			4'd4:    c = 8'h75;
			4'd5:    c = 8'h6c;
			4'd6:    c = 8'h61;
			4'd7:    c = 8'h74;
			4'd8:    c = 8'h65;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dtrm_text_if.sv
// character channel: one ascii character per beat with end-of-token mark
`default_nettype none

interface dtrm_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       token_end;

	modport source(output valid, output character, output token_end, input ready);
	modport sink(input valid, input character, input token_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dtrm_result_if.sv
// result channel: status with maximum, minimum and mean per beat
`default_nettype none

interface dtrm_result_if #(
	parameter int VALUE_WIDTH = dtrm_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic signed [VALUE_WIDTH-1:0] maximum;
	logic signed [VALUE_WIDTH-1:0] minimum;
	logic signed [VALUE_WIDTH-1:0] mean;

	modport source(output valid, output status, output maximum, output minimum,
		output mean, input ready);
	modport sink(input valid, input status, input maximum, input minimum,
		input mean, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dtrm_divider.sv
// bit-serial restoring divider for the mean, truncates toward zero
`default_nettype none

module dtrm_divider #(
	parameter int VALUE_WIDTH = dtrm_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = dtrm_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [VALUE_WIDTH+COUNT_WIDTH-1:0] sum,
	input  wire logic [COUNT_WIDTH-1:0]        count,
	output logic                               busy,
	output logic [VALUE_WIDTH-1:0]             mean
);
	import dtrm_pkg::*;

	localparam int SUM_W = VALUE_WIDTH + COUNT_WIDTH;
	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]       quo_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [COUNT_WIDTH-1:0] div_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;

	logic [COUNT_WIDTH:0]   trial;
	logic                   ge;
	logic [COUNT_WIDTH:0]   diff;
	logic [SUM_W-1:0]       abs_sum;

	assign abs_sum = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
	assign trial   = {rem_q, quo_q[SUM_W-1]};
	assign ge      = trial >= {1'b0, div_q};
	assign diff    = trial - {1'b0, div_q};
	assign busy    = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(SUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= abs_sum;
			rem_q <= '0;
			div_q <= count;
			neg_q <= sum[SUM_W-1];
		end else if (busy) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
		end
	end

	assign mean = neg_q ? (~quo_q[VALUE_WIDTH-1:0] + VALUE_WIDTH'(1))
		: quo_q[VALUE_WIDTH-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/dtrm_datapath.sv
// token parser, running statistics and result register
`default_nettype none

module dtrm_datapath #(
	parameter int FRAC_BITS       = dtrm_pkg::FRAC_BITS_DEF,
	parameter int VALUE_WIDTH     = dtrm_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH     = dtrm_pkg::COUNT_WIDTH_DEF,
	parameter int MAX_FRAC_DIGITS = dtrm_pkg::MAX_FRAC_DIGITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [7:0]                         character,
	input  wire logic                               token_end,
	input  wire dtrm_pkg::ctrl_cmd_t                cmd,
	output dtrm_pkg::event_kind_t                   ev,
	output logic [VALUE_WIDTH+COUNT_WIDTH-1:0]      sum,
	output logic [COUNT_WIDTH-1:0]                  count,
	input  wire logic [VALUE_WIDTH-1:0]             div_mean,
	output logic [1:0]                              result_status,
	output logic signed [VALUE_WIDTH-1:0]           result_maximum,
	output logic signed [VALUE_WIDTH-1:0]           result_minimum,
	output logic signed [VALUE_WIDTH-1:0]           result_mean
);
	import dtrm_pkg::*;

	localparam int MAG_W    = VALUE_WIDTH - 1;
	localparam int SUM_W    = VALUE_WIDTH + COUNT_WIDTH;
	localparam int FD_W     = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int FD_DEPTH = 1 << FD_W;
	localparam int EXT_W    = VALUE_WIDTH + FRAC_BITS + 4;
	localparam logic [MAG_W-1:0] MAG_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// rounded weight of fraction digit d at place k+1
	logic [FRAC_BITS-1:0] frac_tab [FD_DEPTH][16];

	for (genvar k = 0; k < FD_DEPTH; k++) begin : g_place
		localparam longint unsigned TEN = 64'd10 ** (k + 1);
		for (genvar d = 0; d < 16; d++) begin : g_digit
			localparam longint unsigned W = (k < MAX_FRAC_DIGITS && d < 10)
				? ((64'(d) << (FRAC_BITS + 1)) + TEN) / (2 * TEN) : 64'd0;
			assign frac_tab[k][d] = W[FRAC_BITS-1:0];
		end
	end

	// token state
	logic [MAG_W-1:0] mag_q;
	logic             point_q;
	logic             neg_q;
	logic [FD_W-1:0]  fd_q;
	logic [3:0]       pos_q;
	logic             kw_q;
	logic             bad_q;

	// number pipeline
	logic                          num_valid_s1;
	logic [MAG_W-1:0]              mag_s1;
	logic                          neg_s1;
	logic                          num_valid_s2;
	logic signed [VALUE_WIDTH-1:0] v_s2;

	// running statistics
	logic signed [VALUE_WIDTH-1:0] max_q;
	logic signed [VALUE_WIDTH-1:0] min_q;
	logic [SUM_W-1:0]              sum_q;
	logic [COUNT_WIDTH-1:0]        count_q;

	logic             is_digit;
	logic [3:0]       digit;
	logic [EXT_W-1:0] mul10;
	logic [EXT_W-1:0] frac_add;
	logic [MAG_W-1:0] int_sat;
	logic [MAG_W-1:0] frac_sat;
	logic [MAG_W-1:0] mag_n;
	logic             point_n;
	logic             neg_n;
	logic [FD_W-1:0]  fd_n;
	logic             bad_n;
	logic             kw_n;
	logic             number_fire;
	logic             stats_clear;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_add;

	assign is_digit = character >= CH_ZERO && character <= CH_NINE;
	assign digit    = character[3:0];
	assign kw_n     = kw_q && (pos_q < 4'(KW_LEN)) && (character == kw_char(pos_q));

	assign mul10 = (EXT_W'(mag_q) << 3) + (EXT_W'(mag_q) << 1)
		+ (EXT_W'(digit) << FRAC_BITS);
	assign frac_add = EXT_W'(mag_q) + EXT_W'(frac_tab[fd_q][digit]);
	assign int_sat  = (mul10 > EXT_W'(MAG_MAX)) ? MAG_MAX : mul10[MAG_W-1:0];
	assign frac_sat = (frac_add > EXT_W'(MAG_MAX)) ? MAG_MAX : frac_add[MAG_W-1:0];

	always_comb begin
		mag_n   = mag_q;
		point_n = point_q;
		neg_n   = neg_q;
		fd_n    = fd_q;
		bad_n   = bad_q;
		if (!bad_q) begin
			priority if (is_digit) begin
				if (!point_q) begin
					mag_n = int_sat;
				end else if (fd_q < FD_W'(MAX_FRAC_DIGITS)) begin
					mag_n = frac_sat;
					fd_n  = fd_q + FD_W'(1);
				end
			end else if (character == CH_POINT && !point_q) begin
				point_n = 1'b1;
			end else if (pos_q == 4'd0 && character == CH_MINUS && !token_end) begin
				neg_n = 1'b1;
			end else begin
				bad_n = 1'b1;
			end
		end
	end

	always_comb begin
		ev = EV_NONE;
		if (token_end) begin
			priority if (kw_n && pos_q == 4'(KW_LEN - 1)) begin
				ev = (count_q == '0) ? EV_EMPTY : EV_STATS;
			end else if (bad_n) begin
				ev = EV_BAD;
			end else begin
				ev = EV_NONE;
			end
		end
	end

	assign number_fire = cmd.step && token_end && ev == EV_NONE;
	assign stats_clear = (cmd.step && (ev == EV_EMPTY || ev == EV_BAD)) || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q   <= '0;
			point_q <= 1'b0;
			neg_q   <= 1'b0;
			fd_q    <= '0;
			pos_q   <= '0;
			kw_q    <= 1'b1;
			bad_q   <= 1'b0;
		end else if (cmd.step) begin
			if (token_end) begin
				mag_q   <= '0;
				point_q <= 1'b0;
				neg_q   <= 1'b0;
				fd_q    <= '0;
				pos_q   <= '0;
				kw_q    <= 1'b1;
				bad_q   <= 1'b0;
			end else begin
				mag_q   <= mag_n;
				point_q <= point_n;
				neg_q   <= neg_n;
				fd_q    <= fd_n;
				pos_q   <= (pos_q == POS_MAX) ? POS_MAX : pos_q + 4'd1;
				kw_q    <= kw_n;
				bad_q   <= bad_n;
			end
		end
	end

	// a clearing token drops numbers still in flight: they came before it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_valid_s1 <= 1'b0;
			num_valid_s2 <= 1'b0;
		end else begin
			num_valid_s1 <= number_fire;
			num_valid_s2 <= num_valid_s1 && !stats_clear;
		end
	end

	always_ff @(posedge clk) begin
		if (number_fire) begin
			mag_s1 <= mag_n;
			neg_s1 <= neg_n;
		end
		if (num_valid_s1) begin
			v_s2 <= neg_s1 ? -$signed({1'b0, mag_s1}) : $signed({1'b0, mag_s1});
		end
	end

	assign sum_wide = {sum_q[SUM_W-1], sum_q} + {{(COUNT_WIDTH+1){v_s2[VALUE_WIDTH-1]}}, v_s2};
	assign sum_add  = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
		? (v_s2[VALUE_WIDTH-1] ? SUM_MIN : SUM_MAX) : sum_wide[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '0;
			min_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else if (stats_clear) begin
			max_q   <= '0;
			min_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else if (num_valid_s2) begin
			if (count_q == '0) begin
				max_q <= v_s2;
				min_q <= v_s2;
				sum_q <= {{COUNT_WIDTH{v_s2[VALUE_WIDTH-1]}}, v_s2};
			end else begin
				if (v_s2 > max_q) begin
					max_q <= v_s2;
				end
				if (v_s2 < min_q) begin
					min_q <= v_s2;
				end
				sum_q <= sum_add;
			end
			if (!(&count_q)) begin
				count_q <= count_q + COUNT_WIDTH'(1);
			end
		end
	end

	assign sum   = sum_q;
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_status  <= STATUS_OK;
			result_maximum <= max_q;
			result_minimum <= min_q;
			result_mean    <= $signed(div_mean);
		end else if (cmd.step && (ev == EV_EMPTY || ev == EV_BAD)) begin
			result_status  <= (ev == EV_EMPTY) ? STATUS_EMPTY : STATUS_BAD;
			result_maximum <= '0;
			result_minimum <= '0;
			result_mean    <= '0;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dtrm_ctrl.sv
// controller: handshakes, divider sequencing and result valid
`default_nettype none

module dtrm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 text_valid,
	output logic                      text_ready,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	input  wire dtrm_pkg::ctrl_stat_t stat,
	output dtrm_pkg::ctrl_cmd_t       cmd
);
	import dtrm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   valid_q;
	logic   slot_free;
	logic   accept;
	logic   load;

	assign slot_free  = !valid_q || result_ready;
	assign text_ready = (state_q == ST_IDLE) && slot_free;
	assign accept     = text_valid && text_ready;

	assign cmd.step      = accept;
	assign cmd.start_div = accept && stat.ev == EV_STATS;
	assign cmd.finish    = (state_q == ST_DIV) && !stat.div_busy && slot_free;

	assign load = (accept && (stat.ev == EV_EMPTY || stat.ev == EV_BAD)) || cmd.finish;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start_div) begin
					state_n = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cmd.finish) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/decimal_text_running_min_max_mean.sv
// Running max, min and mean over signed decimal numbers typed as ASCII text.
// Each character beat carries a token_end mark; a token is a number such as
// -12.375 or the word calculate. Numbers are converted to signed fixed point
// with FRAC_BITS fraction bits (Q16.16 by default), with saturation, and fold
// into the running statistics. calculate, or any invalid token, produces one
// result beat (status, maximum, minimum, mean) and clears the statistics.
// Throughput is one character per cycle while the channel is not stalled. A
// calculate token with numbers behind it stalls the character channel while
// the bit-serial divider forms the mean, one quotient bit per cycle. The
// result register is a single stage: a character is taken only while it is
// empty or being drained in the same cycle.
`default_nettype none

module decimal_text_running_min_max_mean #(
	parameter int FRAC_BITS       = dtrm_pkg::FRAC_BITS_DEF,
	parameter int VALUE_WIDTH     = dtrm_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH     = dtrm_pkg::COUNT_WIDTH_DEF,
	parameter int MAX_FRAC_DIGITS = dtrm_pkg::MAX_FRAC_DIGITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	dtrm_text_if.sink     text,
	dtrm_result_if.source result
);
	import dtrm_pkg::*;

	localparam int SUM_W = VALUE_WIDTH + COUNT_WIDTH;

	ctrl_cmd_t              cmd;
	ctrl_stat_t             stat;
	event_kind_t            ev;
	logic                   div_busy;
	logic [SUM_W-1:0]       sum;
	logic [COUNT_WIDTH-1:0] count;
	logic [VALUE_WIDTH-1:0] div_mean;

	assign stat.ev       = ev;
	assign stat.div_busy = div_busy;

	dtrm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text.valid),
		.text_ready   (text.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	dtrm_datapath #(
		.FRAC_BITS       (FRAC_BITS),
		.VALUE_WIDTH     (VALUE_WIDTH),
		.COUNT_WIDTH     (COUNT_WIDTH),
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.character      (text.character),
		.token_end      (text.token_end),
		.cmd            (cmd),
		.ev             (ev),
		.sum            (sum),
		.count          (count),
		.div_mean       (div_mean),
		.result_status  (result.status),
		.result_maximum (result.maximum),
		.result_minimum (result.minimum),
		.result_mean    (result.mean)
	);

	dtrm_divider #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_div),
		.sum    (sum),
		.count  (count),
		.busy   (div_busy),
		.mean   (div_mean)
	);

	a_no_take_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !text.ready)
		else $error("character taken while divider busy");

	a_div_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |=> div_busy)
		else $error("divider did not start");

	a_finish_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !div_busy && (!result.valid || result.ready))
		else $error("result loaded before divider done or slot free");

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.finish && cmd.step))
		else $error("character taken while finishing mean");

endmodule

`default_nettype wire
